/* src/lap_pkg.sv */
// shared types and constants for the longest arithmetic progression block
// no dependencies
`default_nettype none

package lap_pkg;

  localparam int LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ORDER = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* src/lap_pair_table.sv */
// pair length table: one memory of lengths indexed by {earlier, later} position,
// swept to zero after reset; depends on lap_pkg
`default_nettype none

module lap_pair_table #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  output logic                   ready,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output lap_pkg::len_t          ext_len,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire lap_pkg::len_t     wr_len
);

  lap_pkg::len_t mem [2**ADDR_W];
  lap_pkg::len_t rd_raw;
  logic [ADDR_W-1:0] clr_addr;
  logic clearing;
  logic [lap_pkg::LEN_W:0] base_len;
  logic [lap_pkg::LEN_W:0] sum_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {ADDR_W{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_len;
    end
    rd_raw <= mem[rd_addr];
  end

  // a zero entry stands for a bare pair of length two
  always_comb begin
    base_len = (rd_raw == '0) ? (lap_pkg::LEN_W+1)'(2) : {1'b0, rd_raw};
    sum_len  = base_len + 1'b1;
    if (sum_len > {1'b0, lap_pkg::LEN_MAX}) begin
      ext_len = lap_pkg::LEN_MAX;
    end else begin
      ext_len = sum_len[lap_pkg::LEN_W-1:0];
    end
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

/* src/longest_arith_progression_stream.sv */
// longest arithmetic progression over a non-decreasing stream of values
// depends on lap_pkg and lap_pair_table
// after reset the pair table (4096 entries at the default size) is swept to zero and
// busy drops in the cycle after the sweep ends. a dropped word raises done in the cycle
// after it is accepted; an accepted word walks its stored predecessors newest first,
// each by a read of the middle word, a target step, a search of the falling pointer and
// a read of the candidate, all through the single read port of the value store. one
// word at a time; done lasts one cycle and cannot be held off by the receiver.
`default_nettype none

module longest_arith_progression_stream #(
  parameter int MAX_VALUES = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [31:0]       value,
  output logic                   done,
  output lap_pkg::len_t          best_len,
  output logic [31:0]            best_prev,
  output logic [31:0]            best_last,
  output lap_pkg::status_t       status
);

  localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CNT_W = $clog2(MAX_VALUES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_JRD   = 4'd2;
  localparam logic [3:0] S_JCHK  = 4'd3;
  localparam logic [3:0] S_TGT   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCHK  = 4'd6;
  localparam logic [3:0] S_ERD   = 4'd7;
  localparam logic [3:0] S_ECHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [CNT_W-1:0] count;
  logic [VALUE_BITS-1:0] first_v, newest, num_r, j_r, target_r;
  logic [VALUE_BITS-1:0] best_prev_r, best_last_r;
  lap_pkg::len_t best_len_r;
  lap_pkg::status_t status_r;
  logic [IDX_W-1:0] jx, ix, e, cur_n;
  logic ok;

  logic [VALUE_BITS-1:0] num_in;
  logic accept;

  logic [VALUE_BITS-1:0] vs_mem [MAX_VALUES];
  logic [VALUE_BITS-1:0] vs_rdata;
  logic [IDX_W-1:0] vs_raddr;
  logic vs_we;

  logic pt_ready;
  lap_pkg::len_t pt_len;
  logic pt_wr;
  logic hit;
  logic stop_walk;

  generate
    if (VALUE_BITS >= 32) begin : g_wide
      assign num_in    = VALUE_BITS'(value);
      assign best_prev = best_prev_r[31:0];
      assign best_last = best_last_r[31:0];
    end else begin : g_narrow
      assign num_in    = value[VALUE_BITS-1:0];
      assign best_prev = 32'(best_prev_r);
      assign best_last = 32'(best_last_r);
    end
  endgenerate

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign done     = (state == S_DONE);
  assign best_len = best_len_r;
  assign status   = status_r;

  assign vs_we = accept && !(count != '0 && newest > num_in)
                 && (count < CNT_W'(MAX_VALUES));

  always_comb begin
    unique case (state)
      S_SRD:   vs_raddr = ix;
      S_ERD:   vs_raddr = e;
      default: vs_raddr = jx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vs_we) begin
      vs_mem[count[IDX_W-1:0]] <= num_in;
    end
    vs_rdata <= vs_mem[vs_raddr];
  end

  // the walk ends once the gap to the new word exceeds the span down to the first word
  assign stop_walk = ({1'b0, num_r} + {1'b0, first_v}) > {vs_rdata, 1'b0};
  assign hit   = ok && (vs_rdata == target_r);
  assign pt_wr = (state == S_ECHK) && hit;

  lap_pair_table #(
    .ADDR_W (2 * IDX_W)
  ) u_pair (
    .clk     (clk),
    .rst     (rst),
    .ready   (pt_ready),
    .rd_addr ({e, jx}),
    .ext_len (pt_len),
    .wr_en   (pt_wr),
    .wr_addr ({jx, cur_n}),
    .wr_len  (pt_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      count       <= '0;
      first_v     <= '0;
      newest      <= '0;
      best_len_r  <= '0;
      best_prev_r <= '0;
      best_last_r <= '0;
      status_r    <= lap_pkg::ST_OK;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (pt_ready) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            priority if (count != '0 && newest > num_in) begin
              status_r <= lap_pkg::ST_ORDER;
              state    <= S_DONE;
            end else if (count >= CNT_W'(MAX_VALUES)) begin
              status_r <= lap_pkg::ST_FULL;
              state    <= S_DONE;
            end else begin
              status_r <= lap_pkg::ST_OK;
              if (count == '0) begin
                first_v <= num_in;
              end
              newest <= num_in;
              num_r  <= num_in;
              cur_n  <= count[IDX_W-1:0];
              count  <= count + 1'b1;
              if (best_len_r < lap_pkg::LEN_W'(1)) begin
                best_len_r  <= lap_pkg::LEN_W'(1);
                best_prev_r <= num_in;
                best_last_r <= num_in;
              end
              if (count != '0) begin
                jx    <= IDX_W'(count - 1'b1);
                ix    <= IDX_W'(count - 1'b1);
                state <= S_JRD;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_JRD: begin
          state <= S_JCHK;
        end
        S_JCHK: begin
          j_r <= vs_rdata;
          if (best_len_r < lap_pkg::LEN_W'(2)) begin
            best_len_r  <= lap_pkg::LEN_W'(2);
            best_prev_r <= vs_rdata;
            best_last_r <= num_r;
          end
          state <= stop_walk ? S_DONE : S_TGT;
        end
        S_TGT: begin
          target_r <= VALUE_BITS'({j_r, 1'b0} - {1'b0, num_r});
          state    <= S_SRD;
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (ix != '0 && vs_rdata > target_r) begin
            ix    <= ix - 1'b1;
            state <= S_SRD;
          end else begin
            // the predecessor must sit strictly before the middle word
            if (ix >= jx) begin
              ok <= (jx != '0);
              e  <= jx - 1'b1;
            end else begin
              ok <= 1'b1;
              e  <= ix;
            end
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_ECHK;
        end
        S_ECHK: begin
          if (hit && pt_len > best_len_r) begin
            best_len_r  <= pt_len;
            best_prev_r <= j_r;
            best_last_r <= num_r;
          end
          if (jx == '0) begin
            state <= S_DONE;
          end else begin
            jx    <= jx - 1'b1;
            state <= S_JRD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block still busy after result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted word did not start work");

  a_pair_write_state: assert property (@(posedge clk) disable iff (rst)
      pt_wr |-> (state == S_ECHK) && ok)
    else $error("pair table written outside the extend step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(MAX_VALUES))
    else $error("value count beyond store depth");

  a_ok_has_best: assert property (@(posedge clk) disable iff (rst)
      (done && status_r == lap_pkg::ST_OK) |-> best_len_r != '0)
    else $error("accepted word left no best progression");
`endif

endmodule

`default_nettype wire

/* tb/lap_stream_checker.sv */
`timescale 1ns / 100ps
// scoreboard for longest_arith_progression_stream: predicts the result word of every
// accepted input word and compares it with the done word; depends on lap_pkg

module lap_stream_checker #(
  parameter int MAX_VALUES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] value,
  input  wire logic        done,
  input  lap_pkg::len_t    best_len,
  input  wire logic [31:0] best_prev,
  input  wire logic [31:0] best_last,
  input  lap_pkg::status_t status,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    lap_pkg::len_t    len;
    logic [31:0]      prev;
    logic [31:0]      last;
    lap_pkg::status_t st;
  } best_word_t;

  best_word_t    predicted_best [$];
  logic [31:0]   kept_vals [0:MAX_VALUES-1];
  lap_pkg::len_t run_tab [0:MAX_VALUES*MAX_VALUES-1];
  int unsigned   kept;
  logic [31:0]   first_val;
  logic [31:0]   newest_val;
  lap_pkg::len_t top_len;
  logic [31:0]   top_prev;
  logic [31:0]   top_last;

  // only a strictly longer run replaces the current best
  function automatic void note_run(input logic [31:0] prev, input logic [31:0] last,
                                   input int unsigned len);
    if (len > top_len) begin
      top_len  = lap_pkg::len_t'(len);
      top_prev = prev;
      top_last = last;
    end
  endfunction

  function automatic best_word_t absorb_word(input logic [31:0] num);
    best_word_t  r;
    int          n;
    int          jx;
    int          ix;
    int          e;
    bit          walking;
    bit          found;
    int unsigned run_len;
    logic [31:0] j;
    logic [31:0] gap;
    logic [31:0] target;
    if (kept > 0 && newest_val > num) begin
      r.st = lap_pkg::ST_ORDER;
    end else if (kept >= MAX_VALUES) begin
      r.st = lap_pkg::ST_FULL;
    end else begin
      if (kept == 0) first_val = num;
      newest_val = num;
      note_run(num, num, 1);
      n = kept;
      kept_vals[n] = num;
      kept = n + 1;
      if (n > 0) begin
        jx = n - 1;
        ix = n - 1;
        walking = 1'b1;
        while (walking) begin
          j = kept_vals[jx];
          gap = num - j;
          note_run(j, num, 2);
          if (gap > j - first_val) begin
            walking = 1'b0;
          end else begin
            target = j - gap;
            while (ix > 0 && kept_vals[ix] > target) ix--;
            // the predecessor must sit strictly before the middle element
            e = ix;
            found = 1'b1;
            if (e >= jx) begin
              if (jx == 0) found = 1'b0;
              else e = jx - 1;
            end
            if (found && kept_vals[e] == target) begin
              run_len = (run_tab[e*MAX_VALUES+jx] == 0) ? 2 : run_tab[e*MAX_VALUES+jx];
              run_len = run_len + 1;
              if (run_len > lap_pkg::LEN_MAX) run_len = lap_pkg::LEN_MAX;
              run_tab[jx*MAX_VALUES+n] = lap_pkg::len_t'(run_len);
              note_run(j, num, run_len);
            end
            if (jx == 0) walking = 1'b0;
            else jx--;
          end
        end
      end
      r.st = lap_pkg::ST_OK;
    end
    r.len  = top_len;
    r.prev = top_prev;
    r.last = top_last;
    return r;
  endfunction

  always @(posedge clk) begin
    best_word_t want;
    int         bad;
    if (rst) begin
      predicted_best.delete();
      for (int k = 0; k < MAX_VALUES*MAX_VALUES; k++) run_tab[k] = '0;
      kept       = 0;
      first_val  = '0;
      newest_val = '0;
      top_len    = '0;
      top_prev   = '0;
      top_last   = '0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      bad = 0;
      // the result word is checked before a word accepted at the same edge is added
      if (done === 1'b1) begin
        if (predicted_best.size() == 0) begin
          $display("%0t: result word with nothing expected: len %0d prev %0h last %0h st %0d",
                   $time, best_len, best_prev, best_last, status);
          bad++;
        end else begin
          want = predicted_best.pop_front();
          if (best_len !== want.len) begin
            $display("%0t: best_len expected %0d actual %0d", $time, want.len, best_len);
            bad++;
          end
          if (best_prev !== want.prev) begin
            $display("%0t: best_prev expected %0h actual %0h", $time, want.prev, best_prev);
            bad++;
          end
          if (best_last !== want.last) begin
            $display("%0t: best_last expected %0h actual %0h", $time, want.last, best_last);
            bad++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            bad++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) predicted_best.push_back(absorb_word(value));
      mismatches  <= mismatches + bad;
      outstanding <= predicted_best.size();
    end
  end

endmodule

/* tb/longest_arith_progression_stream_tb.sv */
`timescale 1ns / 100ps
// stimulus and verdict for longest_arith_progression_stream; depends on lap_pkg,
// the block itself and lap_stream_checker

module longest_arith_progression_stream_tb;

  localparam int MAX_VALUES   = 64;
  localparam int TOTAL_WORDS  = 550;
  localparam int LATENCY_TAIL = 700;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic [31:0]      value = '0;
  logic             busy;
  logic             done;
  lap_pkg::len_t    best_len;
  logic [31:0]      best_prev;
  logic [31:0]      best_last;
  lap_pkg::status_t status;
  int               mismatches;
  int               outstanding;

  int          idle_pct = 0;
  int          sent     = 0;
  int          stored   = 0;
  int          dropped  = 0;
  logic [31:0] tail     = '0;

  longest_arith_progression_stream #(.MAX_VALUES(MAX_VALUES), .VALUE_BITS(32)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .done(done),
    .best_len(best_len), .best_prev(best_prev), .best_last(best_last), .status(status)
  );

  lap_stream_checker #(.MAX_VALUES(MAX_VALUES)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value), .done(done),
    .best_len(best_len), .best_prev(best_prev), .best_last(best_last), .status(status),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("longest_arith_progression_stream_tb NOT OK");
    $finish;
  end

  function automatic int idle_for(input int phase);
    case (phase % 4)
      1: return 74;
      3: return 11;
      default: return 0;
    endcase
  endfunction

  // present one word and hold start until the block takes it
  task automatic send_word(input logic [31:0] v);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent++;
    if (stored < MAX_VALUES && (stored == 0 || v >= tail)) begin
      stored++;
      tail = v;
    end else begin
      dropped++;
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_below_tail();
    if (tail > 0) send_word($urandom_range(0, tail - 1));
  endtask

  // arithmetic run with random base and step, some out-of-order words mixed in
  task automatic send_ramp();
    logic [31:0] base;
    logic [31:0] step;
    int          len;
    int          pick;
    pick = $urandom_range(7);
    base = tail + ((pick == 0) ? $urandom_range(0, 1 << 24) : $urandom_range(0, 50));
    pick = $urandom_range(7);
    if (pick == 0) step = 0;
    else if (pick < 5) step = $urandom_range(1, 8);
    else step = $urandom_range(9, 1000);
    len = $urandom_range(3, 8);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_below_tail();
      send_word(base + k * step);
    end
  endtask

  // small steps over a narrow range give many overlapping progressions
  task automatic send_dense();
    int len;
    len = $urandom_range(4, 8);
    for (int k = 0; k < len; k++) send_word(tail + $urandom_range(0, 3));
  endtask

  initial begin
    int phase;
    int pick;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // repeated first value of zero, then a gap-4 run with out-of-order words
    send_word(32'd0);
    send_word(32'd0);
    send_word(32'd0);
    send_word(32'd4);
    send_word(32'd8);
    send_word(32'd12);
    send_word(32'd6);
    send_word(32'd16);
    send_word(32'd16);
    send_word(32'd20);
    send_word(32'd24);
    send_word(32'd2);
    send_word(32'd25);
    send_word(32'd26);
    send_word(32'd27);
    send_word(32'd28);
    wait_drained();

    while (stored < MAX_VALUES) begin
      idle_pct = idle_for(phase);
      phase++;
      pick = $urandom_range(99);
      if (pick < 60) send_ramp();
      else if (pick < 85) send_dense();
      else if (pick < 93) send_below_tail();
      else send_word(tail + $urandom_range(0, 1 << 20));
    end
    wait_drained();

    // store is full: every word is dropped, order check first
    while (sent < TOTAL_WORDS) begin
      if (sent % 60 == 0) begin
        idle_pct = idle_for(phase);
        phase++;
      end
      pick = $urandom_range(99);
      if (pick < 6) send_word(32'hFFFF_FFFF);
      else if (pick < 12) send_word(32'd0);
      else if (pick < 55) send_below_tail();
      else if (pick < 65) send_word(tail);
      else send_word($urandom());
    end
    wait_drained();
    repeat (LATENCY_TAIL) @(posedge clk);

    $display("run covered %0d words: %0d kept in the value store, %0d dropped",
             sent, stored, dropped);
    $display("drops were out of order and store full, with idle phases of 0, 74 and 11 pct");
    if (mismatches == 0 && outstanding == 0) begin
      $display("longest_arith_progression_stream_tb OK");
    end else begin
      $display("longest_arith_progression_stream_tb NOT OK");
    end
    $finish;
  end

endmodule
